// File: rtl/paired_half_slot_allocator_macros.svh
// Assertion macros for the paired half-slot allocator checker.
// Expects clk and arst_n in the scope of each use; no other dependencies.
`ifndef PAIRED_HALF_SLOT_ALLOCATOR_MACROS_SVH
`define PAIRED_HALF_SLOT_ALLOCATOR_MACROS_SVH

// same-cycle implication
`define PHSA_ASSERT_SAME(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication
`define PHSA_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// File: rtl/phsa_pkg.sv
// Shared types and constants for the paired half-slot allocator.
// No dependencies.
`default_nettype none

package phsa_pkg;

	localparam int MAX_SLOTS_DEF  = 64;
	localparam int FREE_DEPTH_DEF = 128;

	localparam logic [1:0] REQ_ALLOC = 2'd0;
	localparam logic [1:0] REQ_FREE  = 2'd1;
	localparam logic [1:0] REQ_CLEAR = 2'd2;

	localparam logic [1:0] ST_OK      = 2'd0;
	localparam logic [1:0] ST_INVALID = 2'd1;
	localparam logic [1:0] ST_FULL    = 2'd2;
	localparam logic [1:0] ST_HELD    = 2'd3;

	typedef struct packed {
		logic       capture;
		logic       set_status;
		logic [1:0] status;
		logic       pop;
		logic       entry_rd;
		logic       grant;
		logic       append;
		logic       free_rd;
		logic       release_half;
		logic       trim_first;
		logic       trim_rd;
		logic       trim_step;
		logic       clear;
		logic       finish;
	} phsa_cmd_t;

	typedef struct packed {
		logic [1:0] req_type;
		logic       hold;
		logic       slot_bad;
		logic       top_zero;
		logic       entry_stale;
		logic       entry_free;
		logic       slots_full;
		logic       sel_taken;
		logic       tail_free;
		logic       count_zero;
		logic       row_empty;
		logic       out_free;
	} phsa_sts_t;

endpackage

`default_nettype wire

// File: rtl/phsa_ctrl.sv
// Request sequencer for the paired half-slot allocator.
// Depends on phsa_pkg (command and status structs, request and status codes).
`default_nettype none

module phsa_ctrl (
	input  wire                 clk,
	input  wire                 arst_n,
	input  wire                 in_valid,
	output logic                in_ready,
	input  phsa_pkg::phsa_sts_t sts,
	output phsa_pkg::phsa_cmd_t cmd
);

	localparam logic [3:0] S_IDLE     = 4'd0;
	localparam logic [3:0] S_DISPATCH = 4'd1;
	localparam logic [3:0] S_POP      = 4'd2;
	localparam logic [3:0] S_ENTRY    = 4'd3;
	localparam logic [3:0] S_ROW      = 4'd4;
	localparam logic [3:0] S_APPEND   = 4'd5;
	localparam logic [3:0] S_FREE_ROW = 4'd6;
	localparam logic [3:0] S_TRIM     = 4'd7;
	localparam logic [3:0] S_TRIM_ROW = 4'd8;
	localparam logic [3:0] S_DONE     = 4'd9;

	logic [3:0] state_q;
	logic [3:0] state_nxt;

	assign in_ready = (state_q == S_IDLE);

	always_comb begin
		cmd       = '0;
		state_nxt = state_q;
		unique case (state_q)
			S_IDLE: begin
				if (in_valid) begin
					cmd.capture = 1'b1;
					state_nxt   = S_DISPATCH;
				end
			end
			S_DISPATCH: begin
				state_nxt = S_DONE;
				case (sts.req_type)
					phsa_pkg::REQ_ALLOC: state_nxt = S_POP;
					phsa_pkg::REQ_FREE: begin
						if (sts.hold) begin
							cmd.set_status = 1'b1;
							cmd.status     = phsa_pkg::ST_HELD;
						end else if (sts.slot_bad) begin
							cmd.set_status = 1'b1;
							cmd.status     = phsa_pkg::ST_INVALID;
						end else begin
							cmd.free_rd = 1'b1;
							state_nxt   = S_FREE_ROW;
						end
					end
					phsa_pkg::REQ_CLEAR: begin
						if (sts.hold) begin
							cmd.set_status = 1'b1;
							cmd.status     = phsa_pkg::ST_HELD;
						end else begin
							cmd.clear = 1'b1;
						end
					end
					default: state_nxt = S_DONE;
				endcase
			end
			S_POP: begin
				if (sts.top_zero) begin
					state_nxt = S_APPEND;
				end else begin
					cmd.pop   = 1'b1;
					state_nxt = S_ENTRY;
				end
			end
			S_ENTRY: begin
				if (sts.entry_stale) begin
					state_nxt = S_POP;
				end else begin
					cmd.entry_rd = 1'b1;
					state_nxt    = S_ROW;
				end
			end
			S_ROW: begin
				if (sts.entry_free) begin
					cmd.grant = 1'b1;
					state_nxt = S_DONE;
				end else begin
					state_nxt = S_POP;
				end
			end
			S_APPEND: begin
				if (sts.slots_full) begin
					cmd.set_status = 1'b1;
					cmd.status     = phsa_pkg::ST_FULL;
				end else begin
					cmd.append = 1'b1;
				end
				state_nxt = S_DONE;
			end
			S_FREE_ROW: begin
				if (!sts.sel_taken) begin
					cmd.set_status = 1'b1;
					cmd.status     = phsa_pkg::ST_INVALID;
					state_nxt      = S_DONE;
				end else if (sts.tail_free) begin
					cmd.trim_first = 1'b1;
					state_nxt      = S_TRIM;
				end else begin
					cmd.release_half = 1'b1;
					state_nxt        = S_DONE;
				end
			end
			S_TRIM: begin
				if (sts.count_zero) begin
					state_nxt = S_DONE;
				end else begin
					cmd.trim_rd = 1'b1;
					state_nxt   = S_TRIM_ROW;
				end
			end
			S_TRIM_ROW: begin
				if (sts.row_empty) begin
					cmd.trim_step = 1'b1;
					state_nxt     = S_TRIM;
				end else begin
					state_nxt = S_DONE;
				end
			end
			S_DONE: begin
				if (sts.out_free) begin
					cmd.finish = 1'b1;
					state_nxt  = S_IDLE;
				end
			end
			default: state_nxt = S_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_nxt;
		end
	end

endmodule

`default_nettype wire

// File: rtl/phsa_datapath.sv
// Datapath for the paired half-slot allocator: request and result registers,
// slot and free-list pointers, half-taken row store and free-list stack store.
// Depends on phsa_pkg (command and status structs, status codes).
`default_nettype none

module phsa_datapath #(
	parameter  int MAX_SLOTS  = phsa_pkg::MAX_SLOTS_DEF,
	parameter  int FREE_DEPTH = phsa_pkg::FREE_DEPTH_DEF,
	localparam int SLOT_W     = $clog2(MAX_SLOTS + 1)
) (
	input  wire                 clk,
	input  wire                 arst_n,
	input  wire                 cfg_write,
	input  wire                 cfg_data,
	input  wire  [1:0]          req_type,
	input  wire  [SLOT_W-1:0]   slot_number,
	input  wire                 half_select,
	input  phsa_pkg::phsa_cmd_t cmd,
	output phsa_pkg::phsa_sts_t sts,
	output logic                out_valid,
	input  wire                 out_ready,
	output logic [1:0]          status,
	output logic [SLOT_W-1:0]   granted_slot,
	output logic                granted_half,
	output logic                slot_created,
	output logic [SLOT_W-1:0]   slots_released,
	output logic [SLOT_W-1:0]   slots_in_use,
	output logic                list_overflow
);

	localparam int ROW_W  = $clog2(MAX_SLOTS);
	localparam int TOP_W  = $clog2(FREE_DEPTH + 1);
	localparam int STK_AW = $clog2(FREE_DEPTH);
	localparam int ENT_W  = SLOT_W + 1;

	logic              hold_q;
	logic [1:0]        req_q;
	logic [SLOT_W-1:0] slot_q;
	logic              half_q;
	logic [SLOT_W-1:0] count_q;
	logic [TOP_W-1:0]  top_q;

	logic [1:0]        taken_mem [MAX_SLOTS];
	logic [ENT_W-1:0]  stack_mem [FREE_DEPTH];
	logic [1:0]        row_rd_q;
	logic [ENT_W-1:0]  stk_rd_q;

	logic [1:0]        st_q;
	logic [SLOT_W-1:0] gslot_q;
	logic              ghalf_q;
	logic              created_q;
	logic [SLOT_W-1:0] released_q;
	logic              ovf_q;

	logic              out_valid_q;
	logic [1:0]        status_q;
	logic [SLOT_W-1:0] granted_slot_q;
	logic              granted_half_q;
	logic              slot_created_q;
	logic [SLOT_W-1:0] slots_released_q;
	logic [SLOT_W-1:0] slots_in_use_q;
	logic              list_overflow_q;

	logic [SLOT_W-1:0] ent_slot;
	logic              ent_half;
	logic              stack_full;
	logic [SLOT_W-1:0] new_slot;
	logic [ROW_W-1:0]  ent_row;
	logic [ROW_W-1:0]  slot_row;
	logic [ROW_W-1:0]  tail_row;
	logic [ROW_W-1:0]  new_row;
	logic              row_re;
	logic [ROW_W-1:0]  row_raddr;
	logic              row_we;
	logic [ROW_W-1:0]  row_waddr;
	logic [1:0]        row_wdata;
	logic              stk_we;
	logic [STK_AW-1:0] stk_raddr;
	logic [STK_AW-1:0] stk_waddr;
	logic [ENT_W-1:0]  stk_wdata;

	assign ent_slot   = stk_rd_q[ENT_W-1:1];
	assign ent_half   = stk_rd_q[0];
	assign stack_full = (top_q == TOP_W'(FREE_DEPTH));
	assign new_slot   = count_q + 1'b1;
	assign ent_row    = ROW_W'(ent_slot - 1'b1);
	assign slot_row   = ROW_W'(slot_q - 1'b1);
	assign tail_row   = ROW_W'(count_q - 1'b1);
	assign new_row    = ROW_W'(count_q);

	assign row_re = cmd.entry_rd | cmd.free_rd | cmd.trim_rd;

	always_comb begin
		if (cmd.entry_rd) begin
			row_raddr = ent_row;
		end else if (cmd.free_rd) begin
			row_raddr = slot_row;
		end else begin
			row_raddr = tail_row;
		end
	end

	// row bit 1 is half 1, bit 0 is half 0
	always_comb begin
		row_we    = cmd.grant | cmd.append | cmd.release_half;
		row_waddr = slot_row;
		row_wdata = row_rd_q & ~{half_q, ~half_q};
		if (cmd.grant) begin
			row_waddr = ent_row;
			row_wdata = row_rd_q | {ent_half, ~ent_half};
		end else if (cmd.append) begin
			row_waddr = new_row;
			row_wdata = 2'b10;
		end
	end

	assign stk_we    = (cmd.append | cmd.release_half) & ~stack_full;
	assign stk_raddr = STK_AW'(top_q - 1'b1);
	assign stk_waddr = STK_AW'(top_q);
	assign stk_wdata = cmd.append ? {new_slot, 1'b0} : {slot_q, half_q};

	always_ff @(posedge clk) begin
		if (row_we) begin
			taken_mem[row_waddr] <= row_wdata;
		end
		if (row_re) begin
			row_rd_q <= taken_mem[row_raddr];
		end
	end

	always_ff @(posedge clk) begin
		if (stk_we) begin
			stack_mem[stk_waddr] <= stk_wdata;
		end
		if (cmd.pop) begin
			stk_rd_q <= stack_mem[stk_raddr];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hold_q      <= 1'b0;
			count_q     <= '0;
			top_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (cfg_write) begin
				hold_q <= cfg_data;
			end
			if (cmd.append) begin
				count_q <= new_slot;
			end else if (cmd.trim_first || cmd.trim_step) begin
				count_q <= count_q - 1'b1;
			end else if (cmd.clear) begin
				count_q <= '0;
			end
			if (cmd.pop) begin
				top_q <= top_q - 1'b1;
			end else if (stk_we) begin
				top_q <= top_q + 1'b1;
			end else if (cmd.clear) begin
				top_q <= '0;
			end
			if (cmd.finish) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.capture) begin
			req_q      <= req_type;
			slot_q     <= slot_number;
			half_q     <= half_select;
			st_q       <= phsa_pkg::ST_OK;
			gslot_q    <= '0;
			ghalf_q    <= 1'b0;
			created_q  <= 1'b0;
			released_q <= '0;
			ovf_q      <= 1'b0;
		end
		if (cmd.set_status) begin
			st_q <= cmd.status;
		end
		if (cmd.grant) begin
			gslot_q <= ent_slot;
			ghalf_q <= ent_half;
		end
		if (cmd.append) begin
			gslot_q   <= new_slot;
			ghalf_q   <= 1'b1;
			created_q <= 1'b1;
		end
		if (cmd.append || cmd.release_half) begin
			ovf_q <= stack_full;
		end
		if (cmd.trim_first) begin
			released_q <= SLOT_W'(1);
		end else if (cmd.trim_step) begin
			released_q <= released_q + 1'b1;
		end else if (cmd.clear) begin
			released_q <= count_q;
		end
		if (cmd.finish) begin
			status_q         <= st_q;
			granted_slot_q   <= gslot_q;
			granted_half_q   <= ghalf_q;
			slot_created_q   <= created_q;
			slots_released_q <= released_q;
			slots_in_use_q   <= count_q;
			list_overflow_q  <= ovf_q;
		end
	end

	always_comb begin
		sts.req_type    = req_q;
		sts.hold        = hold_q;
		sts.slot_bad    = (slot_q == '0) || (slot_q > count_q);
		sts.top_zero    = (top_q == '0);
		sts.entry_stale = (ent_slot == '0) || (ent_slot > count_q);
		sts.entry_free  = ~row_rd_q[ent_half];
		sts.slots_full  = (count_q >= SLOT_W'(MAX_SLOTS));
		sts.sel_taken   = row_rd_q[half_q];
		sts.tail_free   = (slot_q == count_q) && ~row_rd_q[~half_q];
		sts.count_zero  = (count_q == '0);
		sts.row_empty   = (row_rd_q == 2'b00);
		sts.out_free    = ~out_valid_q | out_ready;
	end

	assign out_valid      = out_valid_q;
	assign status         = status_q;
	assign granted_slot   = granted_slot_q;
	assign granted_half   = granted_half_q;
	assign slot_created   = slot_created_q;
	assign slots_released = slots_released_q;
	assign slots_in_use   = slots_in_use_q;
	assign list_overflow  = list_overflow_q;

endmodule

`default_nettype wire

// File: rtl/paired_half_slot_allocator.sv
// Top level of the paired half-slot allocator: sequencer plus datapath.
// Depends on phsa_pkg, phsa_ctrl, phsa_datapath.
//
//   channel  direction  handshake               payload
//   in       to block   in_valid / in_ready     req_type, slot_number, half_select
//   out      from block out_valid / out_ready   status, granted_slot, granted_half,
//                                               slot_created, slots_released,
//                                               slots_in_use, list_overflow
//   cfg      to block   cfg_write               cfg_data (hold_releases)
//
// One request at a time. Clear, unknown, held and out-of-range free requests are settled at dispatch;
// other frees read the selected row, and a tail free then checks and trims the empty rows below it;
// an allocate pops free-list entries, dropping stale or taken ones, before it grants, appends or reports full.
// Their cost is set by the single read port of the row store and of the free-list stack.
// A finished result waits in the output register; a new request is taken meanwhile.
// Reset clears the slot count, the free-list pointer and the hold bit; no sweep.
`default_nettype none

module paired_half_slot_allocator #(
	parameter  int MAX_SLOTS  = phsa_pkg::MAX_SLOTS_DEF,
	parameter  int FREE_DEPTH = phsa_pkg::FREE_DEPTH_DEF,
	localparam int SLOT_W     = $clog2(MAX_SLOTS + 1)
) (
	input  wire                clk,
	input  wire                arst_n,
	input  wire                cfg_write,
	input  wire                cfg_data,
	input  wire                in_valid,
	output logic               in_ready,
	input  wire  [1:0]         req_type,
	input  wire  [SLOT_W-1:0]  slot_number,
	input  wire                half_select,
	output logic               out_valid,
	input  wire                out_ready,
	output logic [1:0]         status,
	output logic [SLOT_W-1:0]  granted_slot,
	output logic               granted_half,
	output logic               slot_created,
	output logic [SLOT_W-1:0]  slots_released,
	output logic [SLOT_W-1:0]  slots_in_use,
	output logic               list_overflow
);

	phsa_pkg::phsa_cmd_t cmd;
	phsa_pkg::phsa_sts_t sts;

	phsa_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_ready (in_ready),
		.sts      (sts),
		.cmd      (cmd)
	);

	phsa_datapath #(
		.MAX_SLOTS  (MAX_SLOTS),
		.FREE_DEPTH (FREE_DEPTH)
	) u_datapath (
		.clk            (clk),
		.arst_n         (arst_n),
		.cfg_write      (cfg_write),
		.cfg_data       (cfg_data),
		.req_type       (req_type),
		.slot_number    (slot_number),
		.half_select    (half_select),
		.cmd            (cmd),
		.sts            (sts),
		.out_valid      (out_valid),
		.out_ready      (out_ready),
		.status         (status),
		.granted_slot   (granted_slot),
		.granted_half   (granted_half),
		.slot_created   (slot_created),
		.slots_released (slots_released),
		.slots_in_use   (slots_in_use),
		.list_overflow  (list_overflow)
	);

endmodule

`default_nettype wire

// File: rtl/phsa_checker.sv
// Port-level assertions for the paired half-slot allocator, bound to the top level.
// Depends on phsa_pkg and paired_half_slot_allocator_macros.svh.
`default_nettype none

`include "paired_half_slot_allocator_macros.svh"

module phsa_checker #(
	parameter  int MAX_SLOTS = phsa_pkg::MAX_SLOTS_DEF,
	localparam int SLOT_W    = $clog2(MAX_SLOTS + 1)
) (
	input wire              clk,
	input wire              arst_n,
	input wire              in_valid,
	input wire              in_ready,
	input wire              out_valid,
	input wire              out_ready,
	input wire [1:0]        status,
	input wire [SLOT_W-1:0] granted_slot,
	input wire              granted_half,
	input wire              slot_created,
	input wire [SLOT_W-1:0] slots_released,
	input wire [SLOT_W-1:0] slots_in_use,
	input wire              list_overflow
);

	`PHSA_ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid && $stable(status) && $stable(granted_slot) && $stable(granted_half) && $stable(slots_in_use) && $stable(slots_released) && $stable(slot_created) && $stable(list_overflow), "result changed while stalled")
	`PHSA_ASSERT_NEXT(a_busy_after_accept, in_valid && in_ready, !in_ready, "request accepted while busy")
	`PHSA_ASSERT_SAME(a_full_grant, out_valid && status == phsa_pkg::ST_FULL, granted_slot == '0 && slots_in_use == SLOT_W'(MAX_SLOTS), "full result with grant or short count")
	`PHSA_ASSERT_SAME(a_created_tail, out_valid && slot_created, status == phsa_pkg::ST_OK && granted_half && granted_slot == slots_in_use, "new slot not at tail")
	`PHSA_ASSERT_SAME(a_held_quiet, out_valid && status == phsa_pkg::ST_HELD, granted_slot == '0 && slots_released == '0 && !list_overflow, "held request had an effect")

endmodule

bind paired_half_slot_allocator phsa_checker #(
	.MAX_SLOTS (MAX_SLOTS)
) u_phsa_checker (
	.clk            (clk),
	.arst_n         (arst_n),
	.in_valid       (in_valid),
	.in_ready       (in_ready),
	.out_valid      (out_valid),
	.out_ready      (out_ready),
	.status         (status),
	.granted_slot   (granted_slot),
	.granted_half   (granted_half),
	.slot_created   (slot_created),
	.slots_released (slots_released),
	.slots_in_use   (slots_in_use),
	.list_overflow  (list_overflow)
);

`default_nettype wire

// File: tb/tb.sv
// Self-checking testbench for paired_half_slot_allocator: directed, fill, stale-drain,
// hold and random request streams, every result compared with an in-file free-list model.
// Depends on phsa_pkg and the allocator RTL only.

module tb;

	localparam int SLOTS = phsa_pkg::MAX_SLOTS_DEF;
	localparam int DEPTH = phsa_pkg::FREE_DEPTH_DEF;
	localparam logic [1:0] REQ_NOP = 2'd3;
	localparam int HOLD_OFF_CYCLES = 200;
	localparam int MAX_SHOWN = 10;

	typedef struct packed {
		logic [1:0] status;
		logic [6:0] slot;
		logic       half;
		logic       created;
		logic [6:0] released;
		logic [6:0] in_use;
		logic       overflow;
	} alloc_result_t;

	logic       clk;
	logic       arst_n = 1'b0;
	logic       cfg_write = 1'b0;
	logic       cfg_data = 1'b0;
	logic       in_valid = 1'b0;
	logic       in_ready;
	logic [1:0] req_type = 2'd0;
	logic [6:0] slot_number = 7'd0;
	logic       half_select = 1'b0;
	logic       out_valid;
	logic       out_ready = 1'b0;
	logic [1:0] status;
	logic [6:0] granted_slot;
	logic       granted_half;
	logic       slot_created;
	logic [6:0] slots_released;
	logic [6:0] slots_in_use;
	logic       list_overflow;

	// allocator model state
	bit         half_taken_m [2*SLOTS];
	int         slot_total = 0;
	logic [7:0] free_list [DEPTH];
	int         free_count = 0;
	bit         hold_m = 1'b0;

	alloc_result_t expected_results [$];
	alloc_result_t seen_result;
	alloc_result_t want_result;

	int  snd_idle_pct = 0;
	int  rcv_stall_pct = 0;
	int  gap_left = 0;
	bit  offering = 1'b0;
	int  hold_offs_asked = 0;
	int  hold_offs_served = 0;
	int  stall_left = 0;
	int  sent_count = 0;
	int  results_checked = 0;
	int  mismatch_count = 0;
	int  full_replies = 0;
	int  tail_trims = 0;
	int  stale_drops = 0;

	paired_half_slot_allocator #(
		.MAX_SLOTS (SLOTS),
		.FREE_DEPTH(DEPTH)
	) u_dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.cfg_write     (cfg_write),
		.cfg_data      (cfg_data),
		.in_valid      (in_valid),
		.in_ready      (in_ready),
		.req_type      (req_type),
		.slot_number   (slot_number),
		.half_select   (half_select),
		.out_valid     (out_valid),
		.out_ready     (out_ready),
		.status        (status),
		.granted_slot  (granted_slot),
		.granted_half  (granted_half),
		.slot_created  (slot_created),
		.slots_released(slots_released),
		.slots_in_use  (slots_in_use),
		.list_overflow (list_overflow)
	);

	always begin
		clk = 1'b0;
		#4;
		clk = 1'b1;
		#4;
	end

	initial begin
		#24_000_000;
		$display("FAILED: results differ");
		$finish;
	end

	function automatic logic push_free(input int s, input logic h);
		if (free_count >= DEPTH) return 1'b1;
		free_list[free_count] = {7'(s), h};
		free_count++;
		return 1'b0;
	endfunction

	task automatic predict_request(input logic [1:0] rt, input logic [6:0] sn,
			input logic hs);
		alloc_result_t r;
		logic [7:0]    e;
		int            es;
		int            s;
		bit            found;
		r = '0;
		found = 1'b0;
		s = int'(sn);
		case (rt)
		phsa_pkg::REQ_ALLOC: begin
			while (free_count > 0 && !found) begin
				free_count--;
				e = free_list[free_count];
				es = int'(e[7:1]);
				if (es >= 1 && es <= slot_total
						&& !half_taken_m[(es-1)*2 + int'(e[0])]) begin
					half_taken_m[(es-1)*2 + int'(e[0])] = 1'b1;
					r.slot = 7'(es);
					r.half = e[0];
					found = 1'b1;
				end else begin
					stale_drops++;
				end
			end
			if (!found) begin
				if (slot_total >= SLOTS) begin
					r.status = phsa_pkg::ST_FULL;
					full_replies++;
				end else begin
					half_taken_m[slot_total*2] = 1'b0;
					half_taken_m[slot_total*2 + 1] = 1'b1;
					slot_total++;
					r.slot = 7'(slot_total);
					r.half = 1'b1;
					r.created = 1'b1;
					r.overflow = push_free(slot_total, 1'b0);
				end
			end
		end
		phsa_pkg::REQ_FREE: begin
			if (hold_m) begin
				r.status = phsa_pkg::ST_HELD;
			end else if (s < 1 || s > slot_total || !half_taken_m[(s-1)*2 + int'(hs)]) begin
				r.status = phsa_pkg::ST_INVALID;
			end else if (s == slot_total && !half_taken_m[(s-1)*2 + int'(!hs)]) begin
				// last taken half of the tail: trim it and any fully free slots below
				slot_total--;
				r.released = 7'd1;
				while (slot_total > 0 && !half_taken_m[(slot_total-1)*2]
						&& !half_taken_m[(slot_total-1)*2 + 1]) begin
					slot_total--;
					r.released = r.released + 7'd1;
				end
				tail_trims++;
			end else begin
				half_taken_m[(s-1)*2 + int'(hs)] = 1'b0;
				r.overflow = push_free(s, hs);
			end
		end
		phsa_pkg::REQ_CLEAR: begin
			if (hold_m) begin
				r.status = phsa_pkg::ST_HELD;
			end else begin
				r.released = 7'(slot_total);
				slot_total = 0;
				free_count = 0;
			end
		end
		default: begin
		end
		endcase
		r.in_use = 7'(slot_total);
		expected_results.push_back(r);
	endtask

	function automatic string show(input alloc_result_t r);
		return $sformatf(
			"status=%0d slot=%0d half=%0d created=%0d released=%0d in_use=%0d ovf=%0d",
			r.status, r.slot, r.half, r.created, r.released, r.in_use, r.overflow);
	endfunction

	always @(negedge clk) begin
		if (arst_n && out_valid && out_ready) begin
			seen_result = {status, granted_slot, granted_half, slot_created,
				slots_released, slots_in_use, list_overflow};
			results_checked++;
			if (expected_results.size() == 0) begin
				mismatch_count++;
				if (mismatch_count <= MAX_SHOWN)
					$display("result with no request outstanding: %s", show(seen_result));
			end else begin
				want_result = expected_results.pop_front();
				if (seen_result.status !== want_result.status
						|| seen_result.slot !== want_result.slot
						|| seen_result.half !== want_result.half
						|| seen_result.created !== want_result.created
						|| seen_result.released !== want_result.released
						|| seen_result.in_use !== want_result.in_use
						|| seen_result.overflow !== want_result.overflow) begin
					mismatch_count++;
					if (mismatch_count <= MAX_SHOWN) begin
						$display("mismatch on result %0d", results_checked);
						$display("  expected %s", show(want_result));
						$display("  actual   %s", show(seen_result));
					end
				end
			end
		end
	end

	// receiver: random stalls plus an occasional long hold-off
	always @(posedge clk) begin
		if (hold_offs_served != hold_offs_asked) begin
			hold_offs_served++;
			stall_left = HOLD_OFF_CYCLES;
		end
		if (stall_left > 0) begin
			stall_left--;
			out_ready <= 1'b0;
		end else begin
			out_ready <= ($urandom_range(99) >= rcv_stall_pct);
		end
	end

	task automatic send_request(input logic [1:0] rt, input logic [6:0] sn, input logic hs);
		repeat (gap_left) @(posedge clk);
		req_type <= rt;
		slot_number <= sn;
		half_select <= hs;
		in_valid <= 1'b1;
		offering = 1'b1;
		do @(negedge clk); while (!in_ready);
		@(posedge clk);
		predict_request(rt, sn, hs);
		sent_count++;
		gap_left = 0;
		while (gap_left < 20 && $urandom_range(99) < snd_idle_pct) gap_left++;
		if (gap_left > 0) begin
			in_valid <= 1'b0;
			offering = 1'b0;
		end
	endtask

	task automatic wait_for_results();
		if (offering) begin
			in_valid <= 1'b0;
			offering = 1'b0;
			@(posedge clk);
		end
		while (expected_results.size() != 0) @(posedge clk);
	endtask

	task automatic set_hold(input logic v);
		wait_for_results();
		cfg_data <= v;
		cfg_write <= 1'b1;
		@(posedge clk);
		cfg_write <= 1'b0;
		hold_m = v;
	endtask

	task automatic set_idling(input int snd, input int rcv);
		snd_idle_pct = snd;
		rcv_stall_pct = rcv;
	endtask

	task automatic pick_taken_half(output bit ok, output logic [6:0] sn, output logic hs);
		int cand [$];
		int pick;
		ok = 1'b0;
		sn = 7'd0;
		hs = 1'b0;
		// lean on the tail slot so trims happen often
		if (slot_total > 0 && $urandom_range(3) == 0) begin
			for (int h = 0; h < 2; h++)
				if (half_taken_m[(slot_total-1)*2 + h]) cand.push_back((slot_total-1)*2 + h);
		end
		if (cand.size() == 0) begin
			for (int i = 0; i < slot_total*2; i++)
				if (half_taken_m[i]) cand.push_back(i);
		end
		if (cand.size() > 0) begin
			pick = cand[$urandom_range(cand.size() - 1)];
			sn = 7'(pick / 2 + 1);
			hs = 1'(pick % 2);
			ok = 1'b1;
		end
	endtask

	task automatic send_random_request(input int grow_pct);
		int         r;
		bit         ok;
		logic [6:0] sn;
		logic       hs;
		r = $urandom_range(999);
		if (r < grow_pct * 10) begin
			send_request(phsa_pkg::REQ_ALLOC, 7'($urandom_range(127)), 1'($urandom_range(1)));
		end else if (r < 940) begin
			pick_taken_half(ok, sn, hs);
			if (ok) send_request(phsa_pkg::REQ_FREE, sn, hs);
			else send_request(phsa_pkg::REQ_ALLOC, 7'($urandom_range(127)),
				1'($urandom_range(1)));
		end else if (r < 975) begin
			send_request(phsa_pkg::REQ_FREE, 7'($urandom_range(127)), 1'($urandom_range(1)));
		end else if (r < 995) begin
			send_request(REQ_NOP, 7'($urandom_range(127)), 1'($urandom_range(1)));
		end else begin
			send_request(phsa_pkg::REQ_CLEAR, 7'($urandom_range(127)), 1'($urandom_range(1)));
		end
	endtask

	task automatic test_directed_cases();
		send_request(phsa_pkg::REQ_ALLOC, 7'd0, 1'b0);
		send_request(phsa_pkg::REQ_FREE, 7'd0, 1'b0);
		send_request(phsa_pkg::REQ_FREE, 7'd1, 1'b0);
		send_request(phsa_pkg::REQ_FREE, 7'd127, 1'b1);
		send_request(phsa_pkg::REQ_FREE, 7'd64, 1'b0);
		send_request(phsa_pkg::REQ_ALLOC, 7'd0, 1'b0);
		send_request(phsa_pkg::REQ_ALLOC, 7'd0, 1'b0);
		send_request(phsa_pkg::REQ_FREE, 7'd1, 1'b1);
		send_request(phsa_pkg::REQ_FREE, 7'd2, 1'b1);
		send_request(phsa_pkg::REQ_ALLOC, 7'd0, 1'b0);
		send_request(phsa_pkg::REQ_FREE, 7'd1, 1'b0);
		send_request(phsa_pkg::REQ_FREE, 7'd1, 1'b1);
		send_request(phsa_pkg::REQ_ALLOC, 7'd127, 1'b1);
		send_request(phsa_pkg::REQ_ALLOC, 7'd0, 1'b0);
		send_request(phsa_pkg::REQ_ALLOC, 7'd0, 1'b0);
		send_request(REQ_NOP, 7'd127, 1'b1);
		set_hold(1'b1);
		send_request(phsa_pkg::REQ_FREE, 7'd2, 1'b1);
		send_request(phsa_pkg::REQ_CLEAR, 7'd0, 1'b0);
		send_request(phsa_pkg::REQ_ALLOC, 7'd0, 1'b0);
		set_hold(1'b0);
		send_request(phsa_pkg::REQ_FREE, 7'd2, 1'b1);
		send_request(phsa_pkg::REQ_CLEAR, 7'd0, 1'b0);
		send_request(phsa_pkg::REQ_FREE, 7'd1, 1'b1);
		send_request(phsa_pkg::REQ_ALLOC, 7'd0, 1'b0);
		send_request(phsa_pkg::REQ_CLEAR, 7'd0, 1'b0);
	endtask

	task automatic test_fill_to_full();
		send_request(phsa_pkg::REQ_CLEAR, 7'd0, 1'b0);
		repeat (2 * SLOTS) send_request(phsa_pkg::REQ_ALLOC, 7'd0, 1'b0);
		repeat (3) send_request(phsa_pkg::REQ_ALLOC, 7'($urandom_range(127)),
			1'($urandom_range(1)));
	endtask

	// free nearly everything, trim back to slot 1, then allocate through the stale entries
	task automatic test_stale_drain();
		int halves [$];
		int j;
		int t;
		for (int i = 2; i < 2 * SLOTS - 1; i++) halves.push_back(i);
		for (int i = halves.size() - 1; i > 0; i--) begin
			j = $urandom_range(i);
			t = halves[i];
			halves[i] = halves[j];
			halves[j] = t;
		end
		foreach (halves[i])
			send_request(phsa_pkg::REQ_FREE, 7'(halves[i] / 2 + 1), 1'(halves[i] % 2));
		send_request(phsa_pkg::REQ_FREE, 7'(SLOTS), 1'b1);
		send_request(phsa_pkg::REQ_ALLOC, 7'd0, 1'b0);
		send_request(phsa_pkg::REQ_CLEAR, 7'd0, 1'b0);
	endtask

	task automatic test_random_mix(input int count);
		for (int i = 0; i < count; i++)
			send_random_request(((i / 100) % 2 == 0) ? 80 : 30);
	endtask

	task automatic test_backpressure();
		hold_offs_asked++;
		repeat (40) send_random_request(70);
		wait_for_results();
	endtask

	task automatic test_hold_window(input int count);
		set_hold(1'b1);
		test_random_mix(count);
		set_hold(1'b0);
	endtask

	initial begin
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		set_idling(0, 0);
		test_directed_cases();
		test_fill_to_full();
		test_stale_drain();
		test_backpressure();
		test_random_mix(280);
		set_idling(59, 0);
		test_random_mix(280);
		set_idling(0, 59);
		test_hold_window(150);
		test_random_mix(130);
		set_idling(31, 31);
		test_random_mix(280);
		wait_for_results();
		repeat (40) @(posedge clk);
		$display("%0d requests sent, %0d results checked, %0d mismatches",
			sent_count, results_checked, mismatch_count);
		$display("slots-full replies %0d, tail trims %0d, stale list entries dropped %0d",
			full_replies, tail_trims, stale_drops);
		if (mismatch_count == 0 && expected_results.size() == 0) begin
			$display("PASSED: all results match");
		end else begin
			$display("FAILED: results differ");
		end
		$finish;
	end

endmodule

// File: sim.f
+incdir+rtl
rtl/phsa_pkg.sv
rtl/phsa_ctrl.sv
rtl/phsa_datapath.sv
rtl/paired_half_slot_allocator.sv
rtl/phsa_checker.sv
tb/tb.sv
